[sv/pafk_pkg.sv]
// Shared types and constants for the planar arm forward kinematics pipeline.
// No dependencies.
package pafk_pkg;

  localparam int RAW_W      = 12;
  localparam int ANGLE_W    = 16;
  localparam int LEN_W      = 14;
  localparam int OUT_W      = 17;
  localparam int Q15_W      = 16;
  localparam int TERM_W     = 17;
  localparam int SUM_W      = 19;

  localparam int PH_STAGES  = 2;
  localparam int SIN_STAGES = 8;
  localparam int LNK_STAGES = 3;
  localparam int NSTAGE     = PH_STAGES + SIN_STAGES + LNK_STAGES;
  localparam int SIN_BASE   = PH_STAGES;
  localparam int LNK_BASE   = PH_STAGES + SIN_STAGES;

  localparam logic signed [31:0] K1 = 32'sd1686629713;
  localparam logic signed [31:0] K3 = 32'sd693598669;
  localparam logic signed [31:0] K5 = 32'sd85569306;
  localparam logic signed [31:0] K7 = 32'sd5026995;
  localparam logic signed [31:0] K9 = 32'sd172272;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

  localparam logic [LEN_W-1:0] BASE_RST  = 14'd1280;
  localparam logic [LEN_W-1:0] UPPER_RST = 14'd2000;
  localparam logic [LEN_W-1:0] FORE_RST  = 14'd2000;
  localparam logic [LEN_W-1:0] HAND_RST  = 14'd1600;

  localparam int CFG_AW = 4;
  typedef enum logic [1:0] {
    REG_BASE  = 2'd0,
    REG_UPPER = 2'd1,
    REG_FORE  = 2'd2,
    REG_HAND  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
  } pipe_ctl_t;

endpackage

[sv/pafk_if.sv]
// Channel interfaces for joint words in and position words out.
// Depends on pafk_pkg.
interface pafk_in_if;
  logic                        valid;
  logic                        ready;
  logic [pafk_pkg::RAW_W-1:0]  shoulder_raw;
  logic [pafk_pkg::RAW_W-1:0]  elbow_raw;
  logic [pafk_pkg::RAW_W-1:0]  wrist_raw;
  modport source (output valid, shoulder_raw, elbow_raw, wrist_raw, input ready);
  modport sink   (input valid, shoulder_raw, elbow_raw, wrist_raw, output ready);
endinterface

interface pafk_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pafk_pkg::OUT_W-1:0]  elbow_x;
  logic signed [pafk_pkg::OUT_W-1:0]  elbow_z;
  logic signed [pafk_pkg::OUT_W-1:0]  wrist_x;
  logic signed [pafk_pkg::OUT_W-1:0]  wrist_z;
  logic signed [pafk_pkg::OUT_W-1:0]  tip_x;
  logic signed [pafk_pkg::OUT_W-1:0]  tip_z;
  modport source (output valid, elbow_x, elbow_z, wrist_x, wrist_z, tip_x, tip_z,
                  input ready);
  modport sink   (input valid, elbow_x, elbow_z, wrist_x, wrist_z, tip_x, tip_z,
                  output ready);
endinterface

[sv/pafk_phase.sv]
// Raw servo counts to joint phases, then accumulation along the arm.
// Two pipeline stages. Depends on pafk_pkg.
module pafk_phase (
  input  logic                         clk,
  input  pafk_pkg::pipe_ctl_t          ctl,
  input  logic [pafk_pkg::RAW_W-1:0]   shoulder_raw,
  input  logic [pafk_pkg::RAW_W-1:0]   elbow_raw,
  input  logic [pafk_pkg::RAW_W-1:0]   wrist_raw,
  output logic [pafk_pkg::ANGLE_W-1:0] a1,
  output logic [pafk_pkg::ANGLE_W-1:0] a2,
  output logic [pafk_pkg::ANGLE_W-1:0] a3
);
  import pafk_pkg::*;

  function automatic logic [ANGLE_W-1:0] to_phase(input logic [RAW_W-1:0] raw);
    logic [16:0] m;
    logic [4:0]  q0;
    logic [16:0] r;
    logic [4:0]  q;
    logic [16:0] p;
    m  = {1'b0, raw, 4'd0} + 17'd2047;
    q0 = m[16:12];
    r  = m - {q0, 12'd0} + {12'd0, q0};
    q  = (r >= 17'd4095) ? q0 + 5'd1 : q0;
    p  = {1'b0, raw, 4'd0} + {12'd0, q};
    return p[15:0] ^ 16'h8000;
  endfunction

  logic [ANGLE_W-1:0] p1_r, p2_r, p3_r;
  logic [ANGLE_W-1:0] a1_r, a2_r, a3_r;
  logic [ANGLE_W-1:0] a2_nxt;

  assign a2_nxt = p1_r + p2_r;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      p1_r <= to_phase(shoulder_raw);
      p2_r <= to_phase(elbow_raw);
      p3_r <= to_phase(wrist_raw);
    end
    if (ctl.en[1]) begin
      a1_r <= p1_r;
      a2_r <= a2_nxt;
      a3_r <= a2_nxt + p3_r;
    end
  end

  assign a1 = a1_r;
  assign a2 = a2_r;
  assign a3 = a3_r;
endmodule

[sv/pafk_sine.sv]
// Pipelined Q1.15 sine: quarter-wave fold, Horner series in Q30, round.
// Eight pipeline stages: fold, square, five Horner multiplies, round. Depends on pafk_pkg.
module pafk_sine (
  input  logic                              clk,
  input  pafk_pkg::pipe_ctl_t               ctl,
  input  logic [pafk_pkg::ANGLE_W-1:0]      phase,
  output logic signed [pafk_pkg::Q15_W-1:0] q15
);
  import pafk_pkg::*;

  localparam int E = SIN_BASE;

  logic [30:0]        x_r  [0:5];
  logic               neg_r[0:6];
  logic [30:0]        x2_r [1:4];
  logic signed [31:0] t_r  [2:5];
  logic signed [31:0] y_r;
  logic signed [Q15_W-1:0] q_r;

  logic [14:0]        off;
  logic [61:0]        xx;
  logic signed [63:0] pm [2:6];
  logic signed [32:0] yb;
  logic signed [17:0] ys;
  logic signed [Q15_W-1:0] mag;

  always_comb begin
    off   = phase[14] ? (15'h4000 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
    xx    = {31'd0, x_r[0]} * {31'd0, x_r[0]};
    pm[2] = $signed({1'b0, x2_r[1]}) * K9;
    pm[3] = $signed({1'b0, x2_r[2]}) * t_r[2];
    pm[4] = $signed({1'b0, x2_r[3]}) * t_r[3];
    pm[5] = $signed({1'b0, x2_r[4]}) * t_r[4];
    pm[6] = $signed({1'b0, x_r[5]}) * t_r[5];
    yb    = {y_r[31], y_r} + 33'sd16384;
    ys    = yb[32:15];
    if (ys > 18'sd32767) begin
      mag = 16'sd32767;
    end else if (ys < 18'sd0) begin
      mag = 16'sd0;
    end else begin
      mag = ys[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[E]) begin
      x_r[0]   <= {off, 16'd0};
      neg_r[0] <= phase[15];
    end
    if (ctl.en[E+1]) begin
      x_r[1]   <= x_r[0];
      neg_r[1] <= neg_r[0];
      x2_r[1]  <= xx[60:30];
    end
    if (ctl.en[E+2]) begin
      x_r[2]   <= x_r[1];
      neg_r[2] <= neg_r[1];
      x2_r[2]  <= x2_r[1];
      t_r[2]   <= K7 - pm[2][61:30];
    end
    if (ctl.en[E+3]) begin
      x_r[3]   <= x_r[2];
      neg_r[3] <= neg_r[2];
      x2_r[3]  <= x2_r[2];
      t_r[3]   <= K5 - pm[3][61:30];
    end
    if (ctl.en[E+4]) begin
      x_r[4]   <= x_r[3];
      neg_r[4] <= neg_r[3];
      x2_r[4]  <= x2_r[3];
      t_r[4]   <= K3 - pm[4][61:30];
    end
    if (ctl.en[E+5]) begin
      x_r[5]   <= x_r[4];
      neg_r[5] <= neg_r[4];
      t_r[5]   <= K1 - pm[5][61:30];
    end
    if (ctl.en[E+6]) begin
      neg_r[6] <= neg_r[5];
      y_r      <= pm[6][61:30];
    end
    if (ctl.en[E+7]) begin
      q_r <= neg_r[6] ? -mag : mag;
    end
  end

  assign q15 = q_r;
endmodule

[sv/pafk_link.sv]
// Link terms, chained sums along the arm and output saturation.
// Three pipeline stages. Depends on pafk_pkg.
module pafk_link (
  input  logic                              clk,
  input  pafk_pkg::pipe_ctl_t               ctl,
  input  logic [pafk_pkg::LEN_W-1:0]        base_height,
  input  logic [pafk_pkg::LEN_W-1:0]        upper_len,
  input  logic [pafk_pkg::LEN_W-1:0]        fore_len,
  input  logic [pafk_pkg::LEN_W-1:0]        hand_len,
  input  logic signed [pafk_pkg::Q15_W-1:0] s1, c1, s2, c2, s3, c3,
  output logic signed [pafk_pkg::OUT_W-1:0] elbow_x, elbow_z,
  output logic signed [pafk_pkg::OUT_W-1:0] wrist_x, wrist_z,
  output logic signed [pafk_pkg::OUT_W-1:0] tip_x, tip_z
);
  import pafk_pkg::*;

  localparam int L = LNK_BASE;

  function automatic logic signed [TERM_W-1:0] term(input logic [LEN_W-1:0] len,
                                                   input logic signed [Q15_W-1:0] q);
    logic signed [31:0] p;
    p = $signed({1'b0, len}) * q;
    p = p + 32'sd16384;
    return p[31:15];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    if (v > 19'sd65535) begin
      return 17'sd65535;
    end else if (v < -19'sd65536) begin
      return -17'sd65536;
    end else begin
      return v[OUT_W-1:0];
    end
  endfunction

  logic signed [TERM_W-1:0] tx_r[0:2];
  logic signed [TERM_W-1:0] tz_r[0:2];
  logic signed [SUM_W-1:0]  sx_r[0:2];
  logic signed [SUM_W-1:0]  sz_r[0:2];
  logic signed [OUT_W-1:0]  o_r [0:5];
  logic signed [SUM_W-1:0]  x1, z1, x2, z2;

  always_comb begin
    x1 = SUM_W'(tx_r[0]);
    z1 = $signed({5'd0, base_height}) + SUM_W'(tz_r[0]);
    x2 = x1 + SUM_W'(tx_r[1]);
    z2 = z1 + SUM_W'(tz_r[1]);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[L]) begin
      tx_r[0] <= term(upper_len, s1);
      tz_r[0] <= term(upper_len, c1);
      tx_r[1] <= term(fore_len, s2);
      tz_r[1] <= term(fore_len, c2);
      tx_r[2] <= term(hand_len, s3);
      tz_r[2] <= term(hand_len, c3);
    end
    if (ctl.en[L+1]) begin
      sx_r[0] <= x1;
      sz_r[0] <= z1;
      sx_r[1] <= x2;
      sz_r[1] <= z2;
      sx_r[2] <= x2 + SUM_W'(tx_r[2]);
      sz_r[2] <= z2 + SUM_W'(tz_r[2]);
    end
    if (ctl.en[L+2]) begin
      o_r[0] <= sat(sx_r[0]);
      o_r[1] <= sat(sz_r[0]);
      o_r[2] <= sat(sx_r[1]);
      o_r[3] <= sat(sz_r[1]);
      o_r[4] <= sat(sx_r[2]);
      o_r[5] <= sat(sz_r[2]);
    end
  end

  assign elbow_x = o_r[0];
  assign elbow_z = o_r[1];
  assign wrist_x = o_r[2];
  assign wrist_z = o_r[3];
  assign tip_x   = o_r[4];
  assign tip_z   = o_r[5];
endmodule

[sv/planar_arm_forward_kinematics.sv]
// Planar three-link arm forward kinematics. Takes one word of three servo
// counts per cycle and returns elbow, wrist and tip x/z one word per cycle,
// both while out_w.ready is not holding the pipeline back. 2 phase stages,
// 8 sine stages (fold, square, five 32x32 Horner multiplies, round; six sine
// units), 3 link stages. Each stage holds its word only while the stage after
// it is full and stalled, so bubbles close up.
// Write the link registers over APB only while no word is in flight.
// Depends on pafk_pkg, pafk_if, pafk_phase, pafk_sine, pafk_link.
module planar_arm_forward_kinematics (
  input  logic                         clk,
  input  logic                         rst_n,
  pafk_in_if.sink                      in_w,
  pafk_out_if.source                   out_w,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pafk_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pafk_pkg::*;

  logic [LEN_W-1:0] base_r, upper_r, fore_r, hand_r;
  reg_idx_t         idx;
  logic             wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RST;
      upper_r <= UPPER_RST;
      fore_r  <= FORE_RST;
      hand_r  <= HAND_RST;
    end else if (wr) begin
      case (idx)
        REG_BASE:  base_r  <= pwdata[LEN_W-1:0];
        REG_UPPER: upper_r <= pwdata[LEN_W-1:0];
        REG_FORE:  fore_r  <= pwdata[LEN_W-1:0];
        REG_HAND:  hand_r  <= pwdata[LEN_W-1:0];
        default:   base_r  <= base_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASE:  prdata = {18'd0, base_r};
      REG_UPPER: prdata = {18'd0, upper_r};
      REG_FORE:  prdata = {18'd0, fore_r};
      REG_HAND:  prdata = {18'd0, hand_r};
      default:   prdata = 32'd0;
    endcase
  end

  logic [NSTAGE-1:0] v_r;
  pipe_ctl_t         ctl;

  always_comb begin
    ctl.en[NSTAGE-1] = !v_r[NSTAGE-1] || out_w.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ctl.en[k] = !v_r[k] || ctl.en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ctl.en[0]) begin
        v_r[0] <= in_w.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (ctl.en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_w.ready  = ctl.en[0];
  assign out_w.valid = v_r[NSTAGE-1];

  logic [ANGLE_W-1:0] a1, a2, a3;
  logic signed [Q15_W-1:0] s1, c1, s2, c2, s3, c3;

  pafk_phase u_phase (
    .clk, .ctl,
    .shoulder_raw (in_w.shoulder_raw),
    .elbow_raw    (in_w.elbow_raw),
    .wrist_raw    (in_w.wrist_raw),
    .a1, .a2, .a3
  );

  pafk_sine u_s1 (.clk, .ctl, .phase(a1),                .q15(s1));
  pafk_sine u_c1 (.clk, .ctl, .phase(a1 + QUARTER_TURN), .q15(c1));
  pafk_sine u_s2 (.clk, .ctl, .phase(a2),                .q15(s2));
  pafk_sine u_c2 (.clk, .ctl, .phase(a2 + QUARTER_TURN), .q15(c2));
  pafk_sine u_s3 (.clk, .ctl, .phase(a3),                .q15(s3));
  pafk_sine u_c3 (.clk, .ctl, .phase(a3 + QUARTER_TURN), .q15(c3));

  pafk_link u_link (
    .clk, .ctl,
    .base_height (base_r),
    .upper_len   (upper_r),
    .fore_len    (fore_r),
    .hand_len    (hand_r),
    .s1, .c1, .s2, .c2, .s3, .c3,
    .elbow_x (out_w.elbow_x),
    .elbow_z (out_w.elbow_z),
    .wrist_x (out_w.wrist_x),
    .wrist_z (out_w.wrist_z),
    .tip_x   (out_w.tip_x),
    .tip_z   (out_w.tip_z)
  );
endmodule

[tb/tb_top.sv]
// Self-checking testbench for planar_arm_forward_kinematics: drives joint words with bursty
// valid, stalls the result side, predicts positions in fixed point and compares whole position words.
// Depends on pafk_pkg, pafk_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import pafk_pkg::*;

  typedef struct packed {
    logic [RAW_W-1:0] sh;
    logic [RAW_W-1:0] el;
    logic [RAW_W-1:0] wr;
  } joints_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] ex, ez, wx, wz, tx, tz;
  } pose_t;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pafk_in_if  in_w();
  pafk_out_if out_w();

  planar_arm_forward_kinematics dut (
    .clk, .rst_n, .in_w(in_w.sink), .out_w(out_w.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk = ~clk;

  logic [LEN_W-1:0] lens [4];
  joints_t pending_joints [$];
  pose_t   expected_poses [$];
  int errors = 0, mismatches = 0, poses_seen = 0, idle_cycles = 0;
  bit driving = 1'b0;
  bit in_taken = 1'b0;
  int burst_left = 0, gap_left = 0, stall_phase = 0;

  function automatic logic [ANGLE_W-1:0] raw_phase(logic [RAW_W-1:0] raw);
    longint p;
    p = ((longint'(raw) << ANGLE_W) + 2047) / 4095;
    return ANGLE_W'(p - (1 << (ANGLE_W - 1)));
  endfunction

  function automatic longint sine15(logic [ANGLE_W-1:0] ph);
    logic [1:0] quad;
    longint off, x, x2, t, y;
    quad = ph[ANGLE_W-1 -: 2];
    off = ph[ANGLE_W-3:0];
    if (quad[0]) off = 64'sd16384 - off;
    x = off << (32 - ANGLE_W);
    if (x > 64'sd1073741824) x = 64'sd1073741824;
    x2 = (x * x) >>> 30;
    t = K9;
    t = K7 - ((x2 * t) >>> 30);
    t = K5 - ((x2 * t) >>> 30);
    t = K3 - ((x2 * t) >>> 30);
    t = K1 - ((x2 * t) >>> 30);
    y = ((x * t) >>> 30);
    y = (y + 16384) >>> 15;
    if (y > 32767) y = 32767;
    if (y < 0) y = 0;
    return quad[1] ? -y : y;
  endfunction

  function automatic longint link_term(logic [LEN_W-1:0] len, longint q);
    return (longint'(len) * q + 16384) >>> 15;
  endfunction

  function automatic logic signed [OUT_W-1:0] clip(longint v);
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return OUT_W'(v);
  endfunction

  function automatic pose_t arm_pose(joints_t j);
    logic [ANGLE_W-1:0] a1, a2, a3;
    longint x1, z1, x2, z2, x3, z3;
    pose_t p;
    a1 = raw_phase(j.sh);
    a2 = a1 + raw_phase(j.el);
    a3 = a2 + raw_phase(j.wr);
    x1 = link_term(lens[REG_UPPER], sine15(a1));
    z1 = lens[REG_BASE] + link_term(lens[REG_UPPER], sine15(a1 + QUARTER_TURN));
    x2 = x1 + link_term(lens[REG_FORE], sine15(a2));
    z2 = z1 + link_term(lens[REG_FORE], sine15(a2 + QUARTER_TURN));
    x3 = x2 + link_term(lens[REG_HAND], sine15(a3));
    z3 = z2 + link_term(lens[REG_HAND], sine15(a3 + QUARTER_TURN));
    p.ex = clip(x1); p.ez = clip(z1); p.wx = clip(x2);
    p.wz = clip(z2); p.tx = clip(x3); p.tz = clip(z3);
    return p;
  endfunction

  // driver: bursts and gaps, change on falling edge
  initial begin
    in_w.valid = 1'b0; in_w.shoulder_raw = '0; in_w.elbow_raw = '0; in_w.wrist_raw = '0;
    out_w.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) void'(pending_joints.pop_front());
      if (in_w.valid && !in_taken) begin
        in_w.valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_w.valid <= 1'b0;
      end else if (driving && pending_joints.size() > 0) begin
        in_w.valid <= 1'b1;
        {in_w.shoulder_raw, in_w.elbow_raw, in_w.wrist_raw} <= pending_joints[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 6);
        end else burst_left <= burst_left - 1;
      end else in_w.valid <= 1'b0;
      stall_phase <= (stall_phase + 1) % 23;
      out_w.ready <= (stall_phase < 8) ? 1'b1 : (stall_phase < 15) ? ($urandom_range(0, 2) != 0)
                     : (stall_phase != 18 && stall_phase != 19);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_w.valid && in_w.ready;
      if (in_w.valid && in_w.ready) begin
        expected_poses.push_back(arm_pose({in_w.shoulder_raw, in_w.elbow_raw, in_w.wrist_raw}));
      end
      if (out_w.valid && out_w.ready) begin
        pose_t got, want;
        got = {out_w.elbow_x, out_w.elbow_z, out_w.wrist_x, out_w.wrist_z,
               out_w.tip_x, out_w.tip_z};
        poses_seen++;
        if (expected_poses.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected word %h", got);
        end else begin
          want = expected_poses.pop_front();
          if (got !== want) begin
            errors++;
            if (mismatches++ < 10)
              $display({"mismatch exp ex=%0d ez=%0d wx=%0d wz=%0d tx=%0d tz=%0d",
                        " / got %0d %0d %0d %0d %0d %0d"},
                       want.ex, want.ez, want.wx, want.wz, want.tx, want.tz,
                       got.ex, got.ez, got.wx, got.wz, got.tx, got.tz);
          end
        end
      end
      if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("planar_arm_forward_kinematics test failed");
        $finish;
      end
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= CFG_AW'(4 * idx); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    lens[idx] = val[LEN_W-1:0];
  endtask

  task automatic run_phase(int n, bit directed);
    joints_t j;
    if (directed) begin
      for (int b = 0; b < RAW_W; b++) begin
        pending_joints.push_back({RAW_W'(1 << b), ~RAW_W'(1 << b), RAW_W'(1 << b)});
      end
      pending_joints.push_back({12'd0, 12'd0, 12'd0});
      pending_joints.push_back({12'd4095, 12'd4095, 12'd4095});
      pending_joints.push_back({12'd2047, 12'd2048, 12'd2047});
      pending_joints.push_back({12'd1024, 12'd3071, 12'd1023});
      pending_joints.push_back({12'd2048, 12'd0, 12'd4095});
      pending_joints.push_back({12'd3071, 12'd1024, 12'd2047});
    end
    repeat (n) begin
      j.sh = $urandom_range(0, 4095); j.el = $urandom_range(0, 4095);
      j.wr = $urandom_range(0, 4095);
      if ($urandom_range(0, 7) == 0) j.sh = $urandom_range(0, 1) ? 12'd4095 : 12'd2047;
      pending_joints.push_back(j);
    end
    driving = 1'b1;
    wait (pending_joints.size() == 0 && expected_poses.size() == 0);
    driving = 1'b0;
    repeat (20) @(posedge clk);
  endtask

  initial begin
    lens[REG_BASE] = BASE_RST; lens[REG_UPPER] = UPPER_RST;
    lens[REG_FORE] = FORE_RST; lens[REG_HAND] = HAND_RST;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    run_phase(130, 1'b1);
    cfg_write(REG_BASE, 32'hFFFF_FFFF); cfg_write(REG_UPPER, 32'h3FFF);
    cfg_write(REG_FORE, 32'h3FFF); cfg_write(REG_HAND, 32'h3FFF);
    run_phase(150, 1'b1);
    cfg_write(REG_BASE, 0); cfg_write(REG_UPPER, 0);
    cfg_write(REG_FORE, 0); cfg_write(REG_HAND, 0);
    run_phase(100, 1'b0);
    repeat (3) begin
      cfg_write(REG_BASE, $urandom); cfg_write(REG_UPPER, $urandom);
      cfg_write(REG_FORE, $urandom); cfg_write(REG_HAND, $urandom);
      run_phase(110, 1'b0);
    end
    $display("covered %0d position words over six length settings incl. all-max and all-zero",
             poses_seen);
    if (errors == 0) $display("planar_arm_forward_kinematics test passed");
    else $display("planar_arm_forward_kinematics test failed");
    $finish;
  end
endmodule
